// ----- hw/rtl/tknb_pkg.sv -----
`default_nettype none
package tknb_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int K_RESET      = 32;
  localparam int DATA_W       = 32;
  localparam int KIND_W       = 2;
  localparam int KUSED_W      = 6;
  localparam int RANK_W       = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_OFFER  = 2'd1,
    KIND_FINISH = 2'd2
  } kind_t;

  typedef struct packed {
    logic [DATA_W-1:0] id;
    logic [DATA_W-1:0] distance;
  } entry_t;

  typedef struct packed {
    logic ins;       // sorted insert of the candidate this cycle
    logic rot;       // readout rotation toward cell 0
    logic occupied;  // cell holds a live entry
    logic limit;     // cell lies within the first k positions
    logic wrap;      // cell is the last live one and refills from the head
  } cell_ctl_t;

endpackage
`default_nettype wire

// ----- hw/rtl/tknb_cell.sv -----
`default_nettype none
module tknb_cell
  import tknb_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire entry_t    cand,
  input  wire entry_t    left,
  input  wire logic      left_gt,
  input  wire entry_t    right,
  input  wire entry_t    head,
  output entry_t         ent,
  output logic           gt
);

  entry_t ent_r;
  entry_t ent_nxt;

  // Strict compare: an equal distance stays ahead of the newcomer.
  assign gt  = !ctl.occupied || (cand.distance < ent_r.distance);
  assign ent = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.ins && ctl.limit) begin
      if (left_gt) begin
        ent_nxt = left;
      end else if (gt) begin
        ent_nxt = cand;
      end
    end else if (ctl.rot) begin
      ent_nxt = ctl.wrap ? head : right;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/top_k_nearest_buffer_top.sv -----
`default_nettype none
// Keeps the k smallest-distance candidates in a sorted row of CAPACITY cells.
// Clear, offer and any unknown kind leave busy low, and the single result strobes
// out_valid through the pend and out_valid registers, so such items may be
// issued every cycle. A finish on an empty row gives a single result too. A
// finish with held entries streams one result per entry on consecutive cycles,
// rank 0 first, while the row rotates through cell 0; busy is high while it
// streams. Results cannot be held off: out_valid lasts exactly one cycle per
// result. Write k_used only while idle.
module top_k_nearest_buffer_top
  import tknb_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire logic [KIND_W-1:0]   in_kind,
  input  wire logic [DATA_W-1:0]   in_candidate_id,
  input  wire logic [DATA_W-1:0]   in_distance,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [KUSED_W-1:0]  cfg_k_used,
  output logic                     out_valid,
  output logic                     out_entry_valid,
  output logic [RANK_W-1:0]        out_rank,
  output logic [DATA_W-1:0]        out_entry_id,
  output logic [DATA_W-1:0]        out_entry_distance,
  output logic [DATA_W-1:0]        out_threshold,
  output logic                     out_last
);

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int KRST = (K_RESET > CAPACITY) ? CAPACITY : K_RESET;

  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] k_r, k_nxt;
  logic [CW-1:0] rd_idx_r, rd_idx_nxt;
  logic          rd_active_r, rd_active_nxt;
  logic          pend_r, pend_nxt;

  logic          accept;
  logic          do_ins;
  logic          rd_last;
  logic [CW-1:0] cfg_k_eff;
  logic [IW-1:0] k_idx;
  logic [DATA_W-1:0] thr;

  entry_t              cand;
  entry_t              ent  [CAPACITY];
  logic [CAPACITY-1:0] gt;
  logic [DATA_W-1:0]   ent_dist [CAPACITY];

  logic              out_valid_r;
  logic              out_entry_valid_r;
  logic [RANK_W-1:0] out_rank_r;
  logic [DATA_W-1:0] out_entry_id_r;
  logic [DATA_W-1:0] out_entry_distance_r;
  logic [DATA_W-1:0] out_threshold_r;
  logic              out_last_r;

  assign busy          = rd_active_r;
  assign cfg_ready     = 1'b1;
  assign accept        = start && !busy;
  assign do_ins        = accept && (kind_t'(in_kind) == KIND_OFFER);
  assign cand.id       = in_candidate_id;
  assign cand.distance = in_distance;
  assign rd_last       = ((rd_idx_r + CW'(1)) == count_r);

  always_comb begin
    if (cfg_k_used == '0) begin
      cfg_k_eff = CW'(1);
    end else if ({1'b0, cfg_k_used} > (KUSED_W + 1)'(CAPACITY)) begin
      cfg_k_eff = CW'(CAPACITY);
    end else begin
      cfg_k_eff = CW'(cfg_k_used);
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      cell_ctl_t ctl;
      entry_t    left_ent;
      entry_t    right_ent;
      logic      left_gt;

      assign ctl.ins      = do_ins;
      assign ctl.rot      = rd_active_r;
      assign ctl.occupied = (CW'(gi) < count_r);
      assign ctl.limit    = (CW'(gi) < k_r);
      assign ctl.wrap     = (CW'(gi + 1) == count_r);

      if (gi == 0) begin : g_first
        assign left_ent = '0;
        assign left_gt  = 1'b0;
      end else begin : g_mid
        assign left_ent = ent[gi-1];
        assign left_gt  = gt[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_end
        assign right_ent = ent[0];
      end else begin : g_inner
        assign right_ent = ent[gi+1];
      end

      assign ent_dist[gi] = ent[gi].distance;

      tknb_cell u_cell (
        .clk     (clk),
        .ctl     (ctl),
        .cand    (cand),
        .left    (left_ent),
        .left_gt (left_gt),
        .right   (right_ent),
        .head    (ent[0]),
        .ent     (ent[gi]),
        .gt      (gt[gi])
      );
    end
  endgenerate

  // The k-th entry only matters once k entries are held.
  assign k_idx = IW'(k_r - CW'(1));
  assign thr   = (count_r >= k_r) ? ent_dist[k_idx] : '1;

  always_comb begin
    count_nxt     = count_r;
    k_nxt         = k_r;
    rd_idx_nxt    = rd_idx_r;
    rd_active_nxt = rd_active_r;
    pend_nxt      = 1'b0;
    if (cfg_valid && cfg_ready) begin
      k_nxt = cfg_k_eff;
      if (count_r > cfg_k_eff) begin
        count_nxt = cfg_k_eff;
      end
    end
    if (accept) begin
      case (kind_t'(in_kind))
        KIND_CLEAR: begin
          count_nxt = '0;
          pend_nxt  = 1'b1;
        end
        KIND_OFFER: begin
          if (count_r < k_r) begin
            count_nxt = count_r + CW'(1);
          end
          pend_nxt = 1'b1;
        end
        KIND_FINISH: begin
          if (count_r != '0) begin
            rd_active_nxt = 1'b1;
            rd_idx_nxt    = '0;
          end else begin
            pend_nxt = 1'b1;
          end
        end
        default: begin
          pend_nxt = 1'b1;
        end
      endcase
    end
    if (rd_active_r) begin
      rd_idx_nxt = rd_idx_r + CW'(1);
      if (rd_last) begin
        rd_active_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      k_r         <= CW'(KRST);
      rd_idx_r    <= '0;
      rd_active_r <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      k_r         <= k_nxt;
      rd_idx_r    <= rd_idx_nxt;
      rd_active_r <= rd_active_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= pend_r || rd_active_r;
    end
  end

  // During readout, cell 0 holds the entry of the current readout rank. The row
  // rotates during readout, so the threshold is captured before the first
  // shift and held for the rest of the burst.
  always_ff @(posedge clk) begin
    if (!rd_active_r || (rd_idx_r == '0)) begin
      out_threshold_r <= thr;
    end
    if (rd_active_r) begin
      out_entry_valid_r    <= 1'b1;
      out_rank_r           <= RANK_W'(rd_idx_r);
      out_entry_id_r       <= ent[0].id;
      out_entry_distance_r <= ent[0].distance;
      out_last_r           <= rd_last;
    end else begin
      out_entry_valid_r    <= 1'b0;
      out_rank_r           <= '0;
      out_entry_id_r       <= '0;
      out_entry_distance_r <= '0;
      out_last_r           <= 1'b1;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_entry_valid    = out_entry_valid_r;
  assign out_rank           = out_rank_r;
  assign out_entry_id       = out_entry_id_r;
  assign out_entry_distance = out_entry_distance_r;
  assign out_threshold      = out_threshold_r;
  assign out_last           = out_last_r;

endmodule
`default_nettype wire

// ----- test/testbench.sv -----
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tknb_pkg::*;

  localparam int CAP = CAPACITY_DEF;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [DATA_W-1:0] ALL_ONES = '1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int NUM_PHASES = 9;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] cand_id;
    logic [DATA_W-1:0] distance;
  } command_t;

  typedef struct {
    logic              entry_valid;
    logic [RANK_W-1:0] rank;
    logic [DATA_W-1:0] entry_id;
    logic [DATA_W-1:0] entry_distance;
    logic [DATA_W-1:0] threshold;
    logic              last;
  } readout_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [KIND_W-1:0]   in_kind;
  logic [DATA_W-1:0]   in_candidate_id;
  logic [DATA_W-1:0]   in_distance;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [KUSED_W-1:0]  cfg_k_used;
  logic                out_valid;
  logic                out_entry_valid;
  logic [RANK_W-1:0]   out_rank;
  logic [DATA_W-1:0]   out_entry_id;
  logic [DATA_W-1:0]   out_entry_distance;
  logic [DATA_W-1:0]   out_threshold;
  logic                out_last;

  command_t command_queue[$];
  readout_t awaited_readout[$];

  // Shadow copy of the sorted buffer.
  logic [DATA_W-1:0]  kept_dist [CAP];
  logic [DATA_W-1:0]  kept_id [CAP];
  int unsigned        kept_count;
  logic [KUSED_W-1:0] k_setting;

  int   idle_pct;
  int   error_count;
  int   cycle_count;
  logic item_taken;

  top_k_nearest_buffer_top DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_kind            (in_kind),
    .in_candidate_id    (in_candidate_id),
    .in_distance        (in_distance),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_k_used         (cfg_k_used),
    .out_valid          (out_valid),
    .out_entry_valid    (out_entry_valid),
    .out_rank           (out_rank),
    .out_entry_id       (out_entry_id),
    .out_entry_distance (out_entry_distance),
    .out_threshold      (out_threshold),
    .out_last           (out_last)
  );

  always #2 clk = ~clk;

  function automatic int unsigned effective_k();
    int unsigned k;
    k = k_setting;
    if (k < 1) k = 1;
    if (k > CAP) k = CAP;
    return k;
  endfunction

  function automatic logic [DATA_W-1:0] kth_distance();
    if (kept_count >= effective_k()) return kept_dist[effective_k() - 1];
    return ALL_ONES;
  endfunction

  function automatic void push_readout(logic valid, logic [RANK_W-1:0] rank,
                                       logic [DATA_W-1:0] eid, logic [DATA_W-1:0] edist,
                                       logic [DATA_W-1:0] thr, logic last);
    readout_t r;
    r.entry_valid    = valid;
    r.rank           = rank;
    r.entry_id       = eid;
    r.entry_distance = edist;
    r.threshold      = thr;
    r.last           = last;
    awaited_readout.push_back(r);
  endfunction

  // Sorted insertion; an equal distance goes behind the earlier arrivals.
  function automatic void insert_candidate(logic [DATA_W-1:0] cid, logic [DATA_W-1:0] d);
    int unsigned k;
    int unsigned pos;
    int unsigned top;
    k = effective_k();
    pos = 0;
    if (kept_count >= k) begin
      if (!(d < kept_dist[k - 1])) return;
      top = k - 1;
    end else begin
      top = kept_count;
    end
    while (pos < top && kept_dist[pos] <= d) pos++;
    for (int unsigned i = top; i > pos; i--) begin
      kept_dist[i] = kept_dist[i - 1];
      kept_id[i]   = kept_id[i - 1];
    end
    kept_dist[pos] = d;
    kept_id[pos]   = cid;
    if (kept_count < k) kept_count++;
  endfunction

  function automatic void predict_nearest(command_t c);
    logic [DATA_W-1:0] thr;
    case (c.kind)
      KIND_CLEAR: kept_count = 0;
      KIND_OFFER: insert_candidate(c.cand_id, c.distance);
      KIND_FINISH: begin
        if (kept_count > 0) begin
          thr = kth_distance();
          for (int unsigned i = 0; i < kept_count; i++) begin
            push_readout(1'b1, RANK_W'(i), kept_id[i], kept_dist[i], thr,
                         (i + 1 == kept_count));
          end
          return;
        end
      end
      default: ;
    endcase
    push_readout(1'b0, '0, '0, '0, kth_distance(), 1'b1);
  endfunction

  function automatic void apply_k(logic [KUSED_W-1:0] value);
    k_setting = value;
    if (kept_count > effective_k()) kept_count = effective_k();
  endfunction

  task automatic report_mismatch(string what, logic [DATA_W-1:0] got,
                                 logic [DATA_W-1:0] want);
    $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  task automatic queue_command(logic [KIND_W-1:0] kind, logic [DATA_W-1:0] cid,
                               logic [DATA_W-1:0] d);
    command_t c;
    c.kind     = kind;
    c.cand_id  = cid;
    c.distance = d;
    command_queue.push_back(c);
  endtask

  task automatic queue_random(int n);
    int sel;
    logic [KIND_W-1:0] kind;
    logic [DATA_W-1:0] d;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(99);
      if (sel < 3) kind = KIND_CLEAR;
      else if (sel < 5) kind = KIND_UNUSED;
      else if (sel < 17) kind = KIND_FINISH;
      else kind = KIND_OFFER;
      sel = $urandom_range(99);
      // A narrow range makes ties common; the wide one exercises every bit.
      if (sel < 40) d = $urandom_range(15);
      else if (sel < 45) d = '0;
      else if (sel < 50) d = ALL_ONES;
      else d = $urandom;
      queue_command(kind, $urandom, d);
    end
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (command_queue.size() != 0 || start || busy || awaited_readout.size() != 0);
  endtask

  task automatic write_k(logic [KUSED_W-1:0] value);
    wait_idle();
    repeat (4) @(posedge clk);
    @(negedge clk);
    cfg_valid  <= 1'b1;
    cfg_k_used <= value;
    do @(posedge clk);
    while (!cfg_ready);
    apply_k(value);
    @(negedge clk);
    cfg_valid  <= 1'b0;
    cfg_k_used <= KUSED_W'($urandom);
  endtask

  // Sender: a beat is held until taken; a new one goes out unless this cycle idles.
  always @(negedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!(start && !item_taken)) begin
      if (command_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
        start           <= 1'b1;
        in_kind         <= command_queue[0].kind;
        in_candidate_id <= command_queue[0].cand_id;
        in_distance     <= command_queue[0].distance;
        void'(command_queue.pop_front());
      end else begin
        start           <= 1'b0;
        in_kind         <= KIND_W'($urandom);
        in_candidate_id <= $urandom;
        in_distance     <= $urandom;
      end
    end
  end

  always @(posedge clk) begin
    readout_t want;
    command_t c;
    if (!rst_n) begin
      item_taken <= 1'b0;
    end else begin
      if (out_valid) begin
        if (awaited_readout.size() == 0) begin
          report_mismatch("unexpected result", out_entry_id, '0);
        end else begin
          want = awaited_readout.pop_front();
          if (out_entry_valid !== want.entry_valid)
            report_mismatch("entry_valid", out_entry_valid, want.entry_valid);
          if (out_rank !== want.rank)
            report_mismatch("rank", out_rank, want.rank);
          if (out_entry_id !== want.entry_id)
            report_mismatch("entry_id", out_entry_id, want.entry_id);
          if (out_entry_distance !== want.entry_distance)
            report_mismatch("entry_distance", out_entry_distance, want.entry_distance);
          if (out_threshold !== want.threshold)
            report_mismatch("threshold", out_threshold, want.threshold);
          if (out_last !== want.last)
            report_mismatch("last", out_last, want.last);
        end
      end
      item_taken <= start && !busy;
      if (start && !busy) begin
        c.kind     = in_kind;
        c.cand_id  = in_candidate_id;
        c.distance = in_distance;
        predict_nearest(c);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int phase_k [NUM_PHASES]   = '{32, 63, 0, 5, 17, 2, 40, 1, 8};
    int phase_idle [NUM_PHASES] = '{0, 85, 0, 85, 18, 0, 18, 85, 0};
    int phase_len [NUM_PHASES]  = '{60, 60, 40, 60, 60, 50, 60, 40, 50};
    rst_n           = 1'b0;
    start           = 1'b0;
    in_kind         = '0;
    in_candidate_id = '0;
    in_distance     = '0;
    cfg_valid       = 1'b0;
    cfg_k_used      = '0;
    cycle_count     = 0;
    error_count     = 0;
    idle_pct        = 0;
    item_taken      = 1'b0;
    kept_count      = 0;
    k_setting       = KUSED_W'(K_RESET);
    for (int i = 0; i < CAP; i++) begin
      kept_dist[i] = '0;
      kept_id[i]   = '0;
    end
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Empty buffer, the unused kind, and the field extremes with the reset k.
    queue_command(KIND_FINISH, ALL_ONES, ALL_ONES);
    queue_command(KIND_UNUSED, '0, '0);
    queue_command(KIND_CLEAR, ALL_ONES, '0);
    queue_command(KIND_OFFER, '0, '0);
    queue_command(KIND_OFFER, ALL_ONES, ALL_ONES);
    queue_command(KIND_OFFER, 32'd1, 32'd5);
    queue_command(KIND_OFFER, 32'd2, 32'd5);
    queue_command(KIND_FINISH, '0, '0);
    queue_command(KIND_UNUSED, ALL_ONES, ALL_ONES);
    wait_idle();

    // With one slot, an equal distance must not displace the held entry.
    write_k(KUSED_W'(1));
    queue_command(KIND_OFFER, 32'd10, 32'd10);
    queue_command(KIND_OFFER, 32'd11, 32'd10);
    queue_command(KIND_OFFER, 32'd12, 32'd9);
    queue_command(KIND_OFFER, 32'd13, ALL_ONES);
    queue_command(KIND_FINISH, '0, '0);
    queue_command(KIND_CLEAR, '0, '0);
    queue_command(KIND_FINISH, '0, '0);
    write_k(KUSED_W'(3));
    queue_command(KIND_OFFER, 32'd20, 32'd7);
    queue_command(KIND_OFFER, 32'd21, 32'd3);
    queue_command(KIND_OFFER, 32'd22, 32'd3);
    queue_command(KIND_OFFER, 32'd23, 32'd3);
    queue_command(KIND_OFFER, 32'd24, 32'd1);
    queue_command(KIND_FINISH, '0, '0);
    // Lowering k below the held count drops the highest ranks.
    write_k(KUSED_W'(2));
    queue_command(KIND_FINISH, '0, '0);

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_k(KUSED_W'(phase_k[p]));
      idle_pct = phase_idle[p];
      queue_random(phase_len[p]);
    end

    wait_idle();
    repeat (40) @(posedge clk);
    if (awaited_readout.size() != 0)
      report_mismatch("results never delivered", awaited_readout.size(), '0);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
